// File: design/pid_conditional_integral_top_defines.svh
// Assertion macros used by the checker file of this block.
`ifndef PID_CONDITIONAL_INTEGRAL_TOP_DEFINES_SVH
`define PID_CONDITIONAL_INTEGRAL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define PCI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define PCI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/pci_pkg.sv
`timescale 1ns / 1ps
package pci_pkg;

  localparam int ERR_W  = 32;
  localparam int SUM_W  = 34;
  localparam int GAIN_W = 24;
  localparam int LIM_W  = 31;
  localparam int SLIM_W = 32;
  localparam int IDX_W  = 3;
  localparam int DATA_W = 32;

  localparam logic CMD_COMPUTE = 1'b0;
  localparam logic CMD_CLEAR   = 1'b1;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN        = 3'd0;
  localparam logic [IDX_W-1:0] REG_KI_TIMES_PERIOD  = 3'd1;
  localparam logic [IDX_W-1:0] REG_KD_TIMES_RATE    = 3'd2;
  localparam logic [IDX_W-1:0] REG_SUM_LIMIT        = 3'd3;
  localparam logic [IDX_W-1:0] REG_DRIVE_LIMIT      = 3'd4;
  localparam logic [IDX_W-1:0] REG_DEADBAND         = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIFFERENCE_LIMIT = 3'd6;

  localparam logic [GAIN_W-1:0] RST_PROP_GAIN        = 24'd52429;
  localparam logic [GAIN_W-1:0] RST_KI_TIMES_PERIOD  = 24'd66;
  localparam logic [GAIN_W-1:0] RST_KD_TIMES_RATE    = 24'd327680;
  localparam logic [SLIM_W-1:0] RST_SUM_LIMIT        = 32'd1638400;
  localparam logic [LIM_W-1:0]  RST_DRIVE_LIMIT      = 31'd98304;
  localparam logic [LIM_W-1:0]  RST_DEADBAND         = 31'd6554;
  localparam logic [LIM_W-1:0]  RST_DIFFERENCE_LIMIT = 31'd2621;

  typedef struct packed {
    logic                    command;
    logic signed [ERR_W-1:0] error_in;
  } pci_in_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] drive;
    logic                    drive_clamped;
  } pci_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] ki_times_period;
    logic [GAIN_W-1:0] kd_times_rate;
    logic [SLIM_W-1:0] sum_limit;
    logic [LIM_W-1:0]  drive_limit;
    logic [LIM_W-1:0]  deadband;
    logic [LIM_W-1:0]  difference_limit;
  } pci_cfg_t;

  typedef struct packed {
    logic prod_load;
    logic out_load;
  } pci_load_t;

endpackage

// File: design/pid_conditional_integral_top.sv
`timescale 1ns / 1ps
// PID drive stage with a conditional integral and clamped sum, difference and drive.
// Input channel (item_valid, item_stall, item): one beat carries a command and a
// signed Q16.16 error. A compute beat updates the error sum and previous error and
// yields one result beat; a clear beat resets that state and yields nothing.
// Output channel (result_valid, result_stall, result): the clamped drive and a flag
// that tells whether the drive limit was hit.
// One beat can be accepted in every cycle while item_stall is low. The state
// update, the three gain multipliers and the final sum with rounding and clamping
// each take one register stage.
// When the receiver raises result_stall the result holds, the stages behind it fill,
// and item_stall rises once the first stage can no longer move.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is always
// ready; writes are meant for times when no beat is in flight. Unknown indexes are
// ignored.
// Reset (rst, synchronous) restores all configuration registers to their defaults,
// clears the error sum and previous error, marks the next step as the first, and
// empties the pipeline.
module pid_conditional_integral_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  pci_pkg::pci_in_t              item,
  output logic                          result_valid,
  input  logic                          result_stall,
  output pci_pkg::pci_out_t             result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pci_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pci_pkg::DATA_W-1:0]    cfg_data
);
  import pci_pkg::*;

  pci_cfg_t                cfg;
  pci_load_t               load;
  logic                    s1_valid;
  logic                    s2_valid;
  logic                    out_open;
  logic                    s2_open;
  logic                    s1_open;
  logic                    accept;
  logic signed [ERR_W-1:0] e_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [ERR_W-1:0] diff_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain        <= RST_PROP_GAIN;
      cfg.ki_times_period  <= RST_KI_TIMES_PERIOD;
      cfg.kd_times_rate    <= RST_KD_TIMES_RATE;
      cfg.sum_limit        <= RST_SUM_LIMIT;
      cfg.drive_limit      <= RST_DRIVE_LIMIT;
      cfg.deadband         <= RST_DEADBAND;
      cfg.difference_limit <= RST_DIFFERENCE_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:        cfg.prop_gain        <= cfg_data[GAIN_W-1:0];
        REG_KI_TIMES_PERIOD:  cfg.ki_times_period  <= cfg_data[GAIN_W-1:0];
        REG_KD_TIMES_RATE:    cfg.kd_times_rate    <= cfg_data[GAIN_W-1:0];
        REG_SUM_LIMIT:        cfg.sum_limit        <= cfg_data[SLIM_W-1:0];
        REG_DRIVE_LIMIT:      cfg.drive_limit      <= cfg_data[LIM_W-1:0];
        REG_DEADBAND:         cfg.deadband         <= cfg_data[LIM_W-1:0];
        REG_DIFFERENCE_LIMIT: cfg.difference_limit <= cfg_data[LIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_open   = !result_valid || !result_stall;
  assign s2_open    = !s2_valid || out_open;
  assign s1_open    = !s1_valid || s2_open;
  assign item_stall = !s1_open;
  assign accept     = item_valid && s1_open;

  assign load.prod_load = s1_valid && s2_open;
  assign load.out_load  = s2_valid && out_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_open) begin
        s1_valid <= accept && (item.command == CMD_COMPUTE);
      end
      if (s2_open) begin
        s2_valid <= s1_valid;
      end
      if (out_open) begin
        result_valid <= s2_valid;
      end
    end
  end

  pci_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .e_q    (e_q),
    .sum_q  (sum_q),
    .diff_q (diff_q)
  );

  pci_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .load   (load),
    .cfg    (cfg),
    .e      (e_q),
    .sum    (sum_q),
    .diff   (diff_q),
    .result (result)
  );

endmodule

// File: design/pci_front.sv
`timescale 1ns / 1ps
module pci_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  accept,
  input  pci_pkg::pci_in_t                      item,
  input  pci_pkg::pci_cfg_t                     cfg,
  output logic signed [pci_pkg::ERR_W-1:0]      e_q,
  output logic signed [pci_pkg::SUM_W-1:0]      sum_q,
  output logic signed [pci_pkg::ERR_W-1:0]      diff_q
);
  import pci_pkg::*;

  logic signed [SUM_W-1:0]   error_sum;
  logic signed [ERR_W-1:0]   previous_error;
  logic                      first_step;

  logic signed [ERR_W-1:0]   e;
  logic signed [ERR_W-1:0]   prev_eff;
  logic        [ERR_W:0]     e_mag;
  logic                      above_band;
  logic signed [SUM_W:0]     sum_raw;
  logic signed [SUM_W:0]     sum_lim;
  logic signed [SUM_W:0]     sum_clamp;
  logic signed [SUM_W-1:0]   sum_next;
  logic signed [ERR_W:0]     diff_raw;
  logic signed [ERR_W:0]     diff_lim;
  logic signed [ERR_W:0]     diff_clamp;

  assign e        = item.error_in;
  assign prev_eff = first_step ? e : previous_error;

  assign e_mag      = e[ERR_W-1] ? ((ERR_W+1)'(0) - {e[ERR_W-1], e}) : {1'b0, e};
  assign above_band = e_mag > {2'b00, cfg.deadband};

  assign sum_raw = {error_sum[SUM_W-1], error_sum} + {{(SUM_W+1-ERR_W){e[ERR_W-1]}}, e};
  assign sum_lim = {{(SUM_W+1-SLIM_W){1'b0}}, cfg.sum_limit};

  always_comb begin
    if (sum_raw > sum_lim) begin
      sum_clamp = sum_lim;
    end else if (sum_raw < -sum_lim) begin
      sum_clamp = -sum_lim;
    end else begin
      sum_clamp = sum_raw;
    end
  end

  assign sum_next = above_band ? sum_clamp[SUM_W-1:0] : error_sum;

  assign diff_raw = {e[ERR_W-1], e} - {prev_eff[ERR_W-1], prev_eff};
  assign diff_lim = {2'b00, cfg.difference_limit};

  always_comb begin
    if (diff_raw > diff_lim) begin
      diff_clamp = diff_lim;
    end else if (diff_raw < -diff_lim) begin
      diff_clamp = -diff_lim;
    end else begin
      diff_clamp = diff_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum      <= '0;
      previous_error <= '0;
      first_step     <= 1'b1;
    end else if (accept) begin
      if (item.command == CMD_CLEAR) begin
        error_sum      <= '0;
        previous_error <= '0;
        first_step     <= 1'b1;
      end else begin
        error_sum      <= sum_next;
        previous_error <= e;
        first_step     <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && item.command == CMD_COMPUTE) begin
      e_q    <= e;
      sum_q  <= sum_next;
      diff_q <= diff_clamp[ERR_W-1:0];
    end
  end

endmodule

// File: design/pci_back.sv
`timescale 1ns / 1ps
module pci_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  pci_pkg::pci_load_t                load,
  input  pci_pkg::pci_cfg_t                 cfg,
  input  logic signed [pci_pkg::ERR_W-1:0]  e,
  input  logic signed [pci_pkg::SUM_W-1:0]  sum,
  input  logic signed [pci_pkg::ERR_W-1:0]  diff,
  output pci_pkg::pci_out_t                 result
);
  import pci_pkg::*;

  localparam int PE_W  = GAIN_W + 1 + ERR_W;
  localparam int PS_W  = GAIN_W + 1 + SUM_W;
  localparam int TOT_W = PS_W + 1;
  localparam logic signed [TOT_W-1:0] HALF = TOT_W'(1) << (FRAC_BITS - 1);

  logic signed [PE_W-1:0]  prod_p;
  logic signed [PS_W-1:0]  prod_i;
  logic signed [PE_W-1:0]  prod_d;
  logic signed [TOT_W-1:0] total;
  logic signed [TOT_W-1:0] rounded;
  logic signed [TOT_W-1:0] q_wide;
  logic signed [TOT_W-1:0] lim;
  logic                    over;
  logic                    under;
  logic signed [ERR_W-1:0] drive;

  always_ff @(posedge clk) begin
    if (load.prod_load) begin
      prod_p <= $signed({1'b0, cfg.prop_gain}) * e;
      prod_i <= $signed({1'b0, cfg.ki_times_period}) * sum;
      prod_d <= $signed({1'b0, cfg.kd_times_rate}) * diff;
    end
  end

  assign total = {{(TOT_W-PE_W){prod_p[PE_W-1]}}, prod_p}
               + {{(TOT_W-PS_W){prod_i[PS_W-1]}}, prod_i}
               + {{(TOT_W-PE_W){prod_d[PE_W-1]}}, prod_d};

  assign rounded = total + HALF;
  assign q_wide  = rounded >>> FRAC_BITS;
  assign lim     = {{(TOT_W-LIM_W){1'b0}}, cfg.drive_limit};
  assign over    = q_wide > lim;
  assign under   = q_wide < -lim;

  always_comb begin
    if (over) begin
      drive = lim[ERR_W-1:0];
    end else if (under) begin
      drive = -lim[ERR_W-1:0];
    end else begin
      drive = q_wide[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load.out_load) begin
      result.drive         <= drive;
      result.drive_clamped <= over || under;
    end
  end

endmodule

// File: design/pci_checker.sv
`timescale 1ns / 1ps
`include "pid_conditional_integral_top_defines.svh"
module pci_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input pci_pkg::pci_in_t  item,
  input logic              result_valid,
  input logic              result_stall,
  input pci_pkg::pci_out_t result
);
  import pci_pkg::*;

  // A stalled result beat stays in place unchanged.
  `PCI_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")

  // The pipeline is empty right after reset.
  `PCI_ASSERT_SAME(a_reset_empty, $past(rst), !result_valid, "result beat shown right after reset")

  // With the receiver taking beats, every stage moves, so the input never stalls.
  `PCI_ASSERT_SAME(a_no_stall_free, !result_stall, !item_stall, "input stalled while the output was free")

  // A compute beat passes the front, product and output registers to the output when nothing stalls.
  `PCI_ASSERT_NEXT(a_latency, item_valid && !item_stall && item.command == CMD_COMPUTE ##1 !result_stall ##1 !result_stall, result_valid, "compute beat did not reach the output in time")

endmodule

bind pid_conditional_integral_top pci_checker u_pci_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import pci_pkg::*;

  localparam int FRAC = 16;
  localparam int MAX_REPORTS = 10;
  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  pci_in_t item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  pci_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  pci_cfg_t cfg_shadow;
  longint integ_sum;
  longint prev_err;
  bit first_pending;
  pci_out_t expected_drive_q[$];

  int tx_mode = 1;
  int rx_mode = 1;
  int hold_req = 0;
  int n_steps = 0;
  int n_clears = 0;
  int n_cfg_writes = 0;
  int n_checked = 0;
  int n_clamped = 0;
  int n_fail = 0;

  always #2 clk = ~clk;

  pid_conditional_integral_top i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic int draw_gap(int mode);
    case (mode)
      0: return 0;
      1: return $urandom_range(0, 18);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
    endcase
  endfunction

  function automatic void pid_step_model(pci_in_t it);
    longint err, mag, diff, total, q, lim, pg, ki, kd;
    pci_out_t r;
    if (it.command == CMD_CLEAR) begin
      integ_sum = 0;
      prev_err = 0;
      first_pending = 1'b1;
      n_clears++;
      return;
    end
    err = $signed(it.error_in);
    if (first_pending) begin
      prev_err = err;
      first_pending = 1'b0;
    end
    mag = (err < 0) ? -err : err;
    lim = cfg_shadow.deadband;
    if (mag > lim) begin
      lim = cfg_shadow.sum_limit;
      integ_sum = clamp_sym(integ_sum + err, lim);
    end
    lim = cfg_shadow.difference_limit;
    diff = clamp_sym(err - prev_err, lim);
    pg = cfg_shadow.prop_gain;
    ki = cfg_shadow.ki_times_period;
    kd = cfg_shadow.kd_times_rate;
    total = pg * err + ki * integ_sum + kd * diff;
    q = (total + (longint'(1) << (FRAC - 1))) >>> FRAC;
    lim = cfg_shadow.drive_limit;
    r.drive_clamped = (q > lim) || (q < -lim);
    q = clamp_sym(q, lim);
    r.drive = q[ERR_W-1:0];
    prev_err = err;
    expected_drive_q = {expected_drive_q, r};
    n_steps++;
  endfunction

  function automatic logic [31:0] pick_value(int width);
    logic [31:0] mask;
    mask = (width >= 32) ? 32'hFFFF_FFFF : (32'h1 << width) - 1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return mask;
      2, 3: return $urandom() & mask;
      default: return $urandom_range(0, 32'h4_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_error();
    logic [31:0] e, db, dl;
    db = cfg_shadow.deadband;
    dl = (cfg_shadow.difference_limit > 31'h10_0000) ? 32'h10_0000 :
         cfg_shadow.difference_limit;
    case ($urandom_range(0, 9))
      0: e = $urandom();
      1: begin
        e = db + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) e = -e;
      end
      2, 3: e = prev_err[31:0] + $urandom_range(0, 2 * dl) - dl;
      4: e = $urandom_range(0, 32'h100_0000) - 32'h80_0000;
      default: e = $urandom_range(0, 32'h4_0000) - 32'h2_0000;
    endcase
    return e;
  endfunction

  task automatic send_item(logic cmd, logic [31:0] e);
    pci_in_t it;
    int gap;
    it.command = cmd;
    it.error_in = e;
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall);
    pid_step_model(it);
    gap = draw_gap(tx_mode);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] data;
    data = value;
    case (idx)
      REG_PROP_GAIN: begin
        data[31:24] = $urandom();
        cfg_shadow.prop_gain = data[GAIN_W-1:0];
      end
      REG_KI_TIMES_PERIOD: begin
        data[31:24] = $urandom();
        cfg_shadow.ki_times_period = data[GAIN_W-1:0];
      end
      REG_KD_TIMES_RATE: begin
        data[31:24] = $urandom();
        cfg_shadow.kd_times_rate = data[GAIN_W-1:0];
      end
      REG_SUM_LIMIT: cfg_shadow.sum_limit = data[SLIM_W-1:0];
      REG_DRIVE_LIMIT: begin
        data[31] = $urandom();
        cfg_shadow.drive_limit = data[LIM_W-1:0];
      end
      REG_DEADBAND: begin
        data[31] = $urandom();
        cfg_shadow.deadband = data[LIM_W-1:0];
      end
      REG_DIFFERENCE_LIMIT: begin
        data[31] = $urandom();
        cfg_shadow.difference_limit = data[LIM_W-1:0];
      end
      default: data = $urandom();
    endcase
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg_writes++;
    @(posedge clk);
  endtask

  task automatic load_cfg(logic [31:0] pg, logic [31:0] ki, logic [31:0] kd,
                          logic [31:0] sl, logic [31:0] dl, logic [31:0] db,
                          logic [31:0] dfl);
    write_reg(REG_PROP_GAIN, pg);
    write_reg(REG_KI_TIMES_PERIOD, ki);
    write_reg(REG_KD_TIMES_RATE, kd);
    write_reg(REG_SUM_LIMIT, sl);
    write_reg(REG_DRIVE_LIMIT, dl);
    write_reg(REG_DEADBAND, db);
    write_reg(REG_DIFFERENCE_LIMIT, dfl);
    write_reg(REG_UNUSED, $urandom());
  endtask

  task automatic test_reset_defaults();
    send_item(CMD_COMPUTE, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h8000_0000);
    send_item(CMD_CLEAR, 32'hFFFF_FFFF);
    send_item(CMD_COMPUTE, RST_DEADBAND);
    send_item(CMD_COMPUTE, RST_DEADBAND + 1);
    send_item(CMD_COMPUTE, -RST_DEADBAND - 1);
    send_item(CMD_COMPUTE, 32'd200000);
    send_item(CMD_COMPUTE, 32'd200000 + RST_DIFFERENCE_LIMIT);
    send_item(CMD_COMPUTE, 32'd199999);
    send_item(CMD_CLEAR, 32'h0000_0000);
  endtask

  task automatic test_rounding_ties();
    wait_idle();
    load_cfg(32'd1, 32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
    send_item(CMD_COMPUTE, 32'd32768);
    send_item(CMD_COMPUTE, -32'sd32768);
    send_item(CMD_COMPUTE, 32'd98304);
    send_item(CMD_COMPUTE, -32'sd98304);
  endtask

  task automatic test_limit_extremes();
    wait_idle();
    load_cfg(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h8000_0000);
    send_item(CMD_COMPUTE, 32'hFFFF_FFFF);
    wait_idle();
    load_cfg(32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
             32'd0, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h7FFF_FFFF);
    send_item(CMD_COMPUTE, 32'h8000_0000);
    send_item(CMD_COMPUTE, 32'h0000_0000);
    send_item(CMD_COMPUTE, 32'h8000_0000);
  endtask

  // A sum built up under a wide limit must survive a lower limit while the
  // error stays inside the deadband, and only be cut back on the next
  // accumulating step.
  task automatic test_sum_held_in_deadband();
    wait_idle();
    load_cfg(32'd0, 32'h1_0000, 32'd0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send_item(CMD_CLEAR, 32'd0);
    repeat (3) send_item(CMD_COMPUTE, 32'd1000000);
    wait_idle();
    write_reg(REG_SUM_LIMIT, 32'd1000000);
    write_reg(REG_DEADBAND, 32'h10_0000);
    send_item(CMD_COMPUTE, 32'd5);
    send_item(CMD_COMPUTE, 32'd2000000);
  endtask

  task automatic test_back_pressure();
    wait_idle();
    load_cfg(RST_PROP_GAIN, RST_KI_TIMES_PERIOD, RST_KD_TIMES_RATE, RST_SUM_LIMIT,
             RST_DRIVE_LIMIT, RST_DEADBAND, RST_DIFFERENCE_LIMIT);
    tx_mode = 0;
    hold_req = 300;
    repeat (48) send_item(CMD_COMPUTE, rand_error());
    tx_mode = 1;
  endtask

  task automatic test_pause_drain();
    repeat (30) send_item(CMD_COMPUTE, rand_error());
    wait_idle();
    repeat (30) send_item(CMD_COMPUTE, rand_error());
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 7; p++) begin
      wait_idle();
      load_cfg(pick_value(24), pick_value(24), pick_value(24), pick_value(32),
               pick_value(31), pick_value(31), pick_value(31));
      for (int i = 0; i < 230; i++) begin
        if (i % 40 == 0) begin
          tx_mode = $urandom_range(0, 2);
          rx_mode = $urandom_range(0, 2);
        end
        if ($urandom_range(0, 24) == 0) send_item(CMD_CLEAR, $urandom());
        else send_item(CMD_COMPUTE, rand_error());
      end
    end
  endtask

  initial begin : result_sink
    int n;
    wait (!rst);
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
      end else begin
        n = draw_gap(rx_mode);
      end
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin : drive_check
    pci_out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_drive_q.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("unexpected beat: drive %0d clamped %0b",
                   result.drive, result.drive_clamped);
      end else begin
        want = expected_drive_q.pop_front();
        n_checked++;
        if (want.drive_clamped) n_clamped++;
        if (result.drive !== want.drive || result.drive_clamped !== want.drive_clamped) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("drive mismatch: expected %0d clamped %0b, got %0d clamped %0b",
                     want.drive, want.drive_clamped, result.drive, result.drive_clamped);
        end
      end
    end
  end

  initial begin
    int drain;
    cfg_shadow.prop_gain = RST_PROP_GAIN;
    cfg_shadow.ki_times_period = RST_KI_TIMES_PERIOD;
    cfg_shadow.kd_times_rate = RST_KD_TIMES_RATE;
    cfg_shadow.sum_limit = RST_SUM_LIMIT;
    cfg_shadow.drive_limit = RST_DRIVE_LIMIT;
    cfg_shadow.deadband = RST_DEADBAND;
    cfg_shadow.difference_limit = RST_DIFFERENCE_LIMIT;
    integ_sum = 0;
    prev_err = 0;
    first_pending = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_rounding_ties();
    test_limit_extremes();
    test_sum_held_in_deadband();
    test_back_pressure();
    test_pause_drain();
    test_random_phases();

    item_valid <= 1'b0;
    drain = 0;
    while (expected_drive_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (10) @(posedge clk);
    if (expected_drive_q.size() != 0) begin
      $display("%0d expected drive results never arrived", expected_drive_q.size());
      n_fail += expected_drive_q.size();
    end
    $display("Checked %0d drive beats (%0d at the limit) from %0d steps and %0d clears.",
             n_checked, n_clamped, n_steps, n_clears);
    $display("Used %0d register writes, with zero and full-scale gains and limits.",
             n_cfg_writes);
    if (n_fail == 0) begin
      $display("[pid_conditional_integral_top] OK");
    end else begin
      $display("[pid_conditional_integral_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Run did not finish in time.");
    $display("[pid_conditional_integral_top] ERROR");
    $finish;
  end

endmodule
